// ===== rtl/radix5_dft_butterfly_defines.svh =====
// assertion macros for the radix-5 dft butterfly
// used by radix5_dft_butterfly.sv, no other dependencies
`ifndef RADIX5_DFT_BUTTERFLY_DEFINES_SVH
`define RADIX5_DFT_BUTTERFLY_DEFINES_SVH

`ifndef SYNTHESIS
`define R5DFT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("r5dft: same-cycle check failed");
`define R5DFT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("r5dft: next-cycle check failed");
`else
`define R5DFT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define R5DFT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/r5dft_pkg.sv =====
// shared constants, types and coefficient rounding for the radix-5 dft butterfly
// no dependencies
`default_nettype none

package r5dft_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // register stages from input port to output port
    localparam int PIPE_STAGES = 6;

    // constant magnitudes scaled by 2^30
    localparam longint unsigned Q30_CX1 = 64'd1342177280;  // 1.25
    localparam longint unsigned Q30_CX2 = 64'd600239927;   // 0.559017
    localparam longint unsigned Q30_S1  = 64'd1021189159;  // 0.951057
    localparam longint unsigned Q30_SS1 = 64'd1652318767;  // 1.538842
    localparam longint unsigned Q30_SS2 = 64'd390059550;   // 0.363271

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;   // stage load enables
        logic [PIPE_STAGES-1:0] vld;  // stage valid bits
    } r5dft_pipe_t;

    // round a q30 magnitude to nearest at frac fraction bits, halves up
    function automatic longint unsigned coef_mag(longint unsigned q30, int frac);
        longint unsigned r;
        if (frac >= 30) begin
            r = q30;
        end else begin
            r = (q30 + (64'd1 << (29 - frac))) >> (30 - frac);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/radix5_dft_butterfly.sv =====
// radix-5 dft butterfly, six register stages: pre-add, pre-add, multiply,
// round, post-add, post-add. one item per cycle sustained while m_ready is
// held high; empty stages fill under an output stall. reset clears only the
// stage valid bits and holds s_ready low. depends on r5dft_pkg, r5dft_ctl,
// r5dft_pre, r5dft_mul, r5dft_post and radix5_dft_butterfly_defines.svh
`default_nettype none

`include "radix5_dft_butterfly_defines.svh"

module radix5_dft_butterfly #(
    parameter int SAMPLE_BITS    = r5dft_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = r5dft_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x0_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x0_im,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x1_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x1_im,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x2_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x2_im,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x3_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x3_im,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x4_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_x4_im,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS+2:0]      m_y0_re,
    output logic signed [SAMPLE_BITS+2:0]      m_y0_im,
    output logic signed [SAMPLE_BITS+2:0]      m_y1_re,
    output logic signed [SAMPLE_BITS+2:0]      m_y1_im,
    output logic signed [SAMPLE_BITS+2:0]      m_y2_re,
    output logic signed [SAMPLE_BITS+2:0]      m_y2_im,
    output logic signed [SAMPLE_BITS+2:0]      m_y3_re,
    output logic signed [SAMPLE_BITS+2:0]      m_y3_im,
    output logic signed [SAMPLE_BITS+2:0]      m_y4_re,
    output logic signed [SAMPLE_BITS+2:0]      m_y4_im
);

    localparam int N = SAMPLE_BITS;

    r5dft_pkg::r5dft_pipe_t pipe;

    logic signed [N+2:0] y0_a_re, y0_a_im, y0_b_re, y0_b_im;
    logic signed [N+1:0] sum_re, sum_im, ds_re, ds_im, dd_re, dd_im;
    logic signed [N:0]   d23_re, d23_im, d14_re, d14_im;
    logic signed [N+3:0] cx1_re, cx2_re, s1_re, ss1_re, ss2_re;
    logic signed [N+3:0] cx1_im, cx2_im, s1_im, ss1_im, ss2_im;

    r5dft_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .pipe    (pipe)
    );

    r5dft_pre #(.N(N)) u_pre_re (
        .aclk (aclk),
        .en   (pipe.en[1:0]),
        .x0   (s_x0_re),
        .x1   (s_x1_re),
        .x2   (s_x2_re),
        .x3   (s_x3_re),
        .x4   (s_x4_re),
        .y0   (y0_a_re),
        .sum  (sum_re),
        .ds   (ds_re),
        .dd   (dd_re),
        .d23  (d23_re),
        .d14  (d14_re)
    );

    r5dft_pre #(.N(N)) u_pre_im (
        .aclk (aclk),
        .en   (pipe.en[1:0]),
        .x0   (s_x0_im),
        .x1   (s_x1_im),
        .x2   (s_x2_im),
        .x3   (s_x3_im),
        .x4   (s_x4_im),
        .y0   (y0_a_im),
        .sum  (sum_im),
        .ds   (ds_im),
        .dd   (dd_im),
        .d23  (d23_im),
        .d14  (d14_im)
    );

    r5dft_mul #(.N(N), .F(COEF_FRAC_BITS)) u_mul_re (
        .aclk   (aclk),
        .en     (pipe.en[3:2]),
        .y0_in  (y0_a_re),
        .sum    (sum_re),
        .ds     (ds_re),
        .dd     (dd_re),
        .d23    (d23_re),
        .d14    (d14_re),
        .y0_out (y0_b_re),
        .r_cx1  (cx1_re),
        .r_cx2  (cx2_re),
        .r_s1   (s1_re),
        .r_ss1  (ss1_re),
        .r_ss2  (ss2_re)
    );

    r5dft_mul #(.N(N), .F(COEF_FRAC_BITS)) u_mul_im (
        .aclk   (aclk),
        .en     (pipe.en[3:2]),
        .y0_in  (y0_a_im),
        .sum    (sum_im),
        .ds     (ds_im),
        .dd     (dd_im),
        .d23    (d23_im),
        .d14    (d14_im),
        .y0_out (y0_b_im),
        .r_cx1  (cx1_im),
        .r_cx2  (cx2_im),
        .r_s1   (s1_im),
        .r_ss1  (ss1_im),
        .r_ss2  (ss2_im)
    );

    r5dft_post #(.N(N)) u_post (
        .aclk   (aclk),
        .en     (pipe.en[5:4]),
        .y0_re  (y0_b_re),
        .y0_im  (y0_b_im),
        .cx1_re (cx1_re),
        .cx2_re (cx2_re),
        .s1_re  (s1_re),
        .ss1_re (ss1_re),
        .ss2_re (ss2_re),
        .cx1_im (cx1_im),
        .cx2_im (cx2_im),
        .s1_im  (s1_im),
        .ss1_im (ss1_im),
        .ss2_im (ss2_im),
        .o0_re  (m_y0_re),
        .o0_im  (m_y0_im),
        .o1_re  (m_y1_re),
        .o1_im  (m_y1_im),
        .o2_re  (m_y2_re),
        .o2_im  (m_y2_im),
        .o3_re  (m_y3_re),
        .o3_im  (m_y3_im),
        .o4_re  (m_y4_re),
        .o4_im  (m_y4_im)
    );

    // any empty stage anywhere means the front can take an item
    `R5DFT_ASSERT_IMP(a_bubble_ready, aclk, aresetn, !(&pipe.vld), s_ready)
    // an accepted item lands in the first stage
    `R5DFT_ASSERT_NXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, pipe.vld[0])
    // an item that does not advance stays put
    `R5DFT_ASSERT_NXT(a_front_holds, aclk, aresetn, pipe.vld[0] && !pipe.en[1], pipe.vld[0])

endmodule

`default_nettype wire

// ===== rtl/r5dft_ctl.sv =====
// pipeline control: per-stage valid bits and load enables with bubble collapse
// depends on r5dft_pkg
`default_nettype none

module r5dft_ctl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output r5dft_pkg::r5dft_pipe_t      pipe
);

    localparam int STAGES = r5dft_pkg::PIPE_STAGES;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] up;
    logic [STAGES-1:0] en;

    // a stage can load when it is empty or its content moves on
    always_comb begin
        rdy[STAGES] = m_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        up[0] = s_valid;
        for (int i = 1; i < STAGES; i++) begin
            up[i] = vld_reg[i-1];
        end
        for (int i = 0; i < STAGES; i++) begin
            en[i]       = rdy[i] && up[i];
            vld_next[i] = rdy[i] ? up[i] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // no item is taken while reset is held
    assign s_ready  = rdy[0] && aresetn;
    assign m_valid  = vld_reg[STAGES-1];
    assign pipe.en  = en;
    assign pipe.vld = vld_reg;

endmodule

`default_nettype wire

// ===== rtl/r5dft_pre.sv =====
// pre-adder stages for one component: pairwise sums and differences, bin 0
// no package dependencies
`default_nettype none

module r5dft_pre #(
    parameter int N = 16
) (
    input  wire logic                aclk,
    input  wire logic [1:0]          en,
    input  wire logic signed [N-1:0] x0,
    input  wire logic signed [N-1:0] x1,
    input  wire logic signed [N-1:0] x2,
    input  wire logic signed [N-1:0] x3,
    input  wire logic signed [N-1:0] x4,
    output logic signed [N+2:0]      y0,
    output logic signed [N+1:0]      sum,
    output logic signed [N+1:0]      ds,
    output logic signed [N+1:0]      dd,
    output logic signed [N:0]        d23,
    output logic signed [N:0]        d14
);

    localparam int W1 = N + 1;
    localparam int W2 = N + 2;
    localparam int W3 = N + 3;

    logic signed [N-1:0]  x0_reg;
    logic signed [W1-1:0] s14_reg, s23_reg, d14_reg, d23_reg;
    logic signed [W3-1:0] y0_reg;
    logic signed [W2-1:0] sum_reg, ds_reg, dd_reg;
    logic signed [W1-1:0] d23_dly_reg, d14_dly_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x0_reg  <= x0;
            s14_reg <= W1'(x1) + W1'(x4);
            s23_reg <= W1'(x2) + W1'(x3);
            d14_reg <= W1'(x1) - W1'(x4);
            d23_reg <= W1'(x2) - W1'(x3);
        end
        if (en[1]) begin
            y0_reg      <= W3'(x0_reg) + W3'(s14_reg) + W3'(s23_reg);
            sum_reg     <= W2'(s14_reg) + W2'(s23_reg);
            ds_reg      <= W2'(s14_reg) - W2'(s23_reg);
            dd_reg      <= W2'(d23_reg) - W2'(d14_reg);
            d23_dly_reg <= d23_reg;
            d14_dly_reg <= d14_reg;
        end
    end

    assign y0  = y0_reg;
    assign sum = sum_reg;
    assign ds  = ds_reg;
    assign dd  = dd_reg;
    assign d23 = d23_dly_reg;
    assign d14 = d14_dly_reg;

endmodule

`default_nettype wire

// ===== rtl/r5dft_mul.sv =====
// constant multiply and round stages for one component
// depends on r5dft_pkg for the coefficient values
`default_nettype none

module r5dft_mul #(
    parameter int N = 16,
    parameter int F = 14
) (
    input  wire logic                aclk,
    input  wire logic [1:0]          en,
    input  wire logic signed [N+2:0] y0_in,
    input  wire logic signed [N+1:0] sum,
    input  wire logic signed [N+1:0] ds,
    input  wire logic signed [N+1:0] dd,
    input  wire logic signed [N:0]   d23,
    input  wire logic signed [N:0]   d14,
    output logic signed [N+2:0]      y0_out,
    output logic signed [N+3:0]      r_cx1,
    output logic signed [N+3:0]      r_cx2,
    output logic signed [N+3:0]      r_s1,
    output logic signed [N+3:0]      r_ss1,
    output logic signed [N+3:0]      r_ss2
);

    localparam int CW = F + 2;       // signed coefficient width
    localparam int PW = N + 2 + CW;  // product width
    localparam int RW = N + 4;       // rounded width

    localparam logic signed [CW-1:0] K_CX1 = CW'(r5dft_pkg::coef_mag(r5dft_pkg::Q30_CX1, F));
    localparam logic signed [CW-1:0] K_CX2 = CW'(r5dft_pkg::coef_mag(r5dft_pkg::Q30_CX2, F));
    localparam logic signed [CW-1:0] K_S1  = CW'(r5dft_pkg::coef_mag(r5dft_pkg::Q30_S1, F));
    localparam logic signed [CW-1:0] K_SS1 = CW'(r5dft_pkg::coef_mag(r5dft_pkg::Q30_SS1, F));
    localparam logic signed [CW-1:0] K_SS2 = CW'(r5dft_pkg::coef_mag(r5dft_pkg::Q30_SS2, F));

    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

    logic signed [PW-1:0] p_cx1_reg, p_cx2_reg, p_s1_reg, p_ss1_reg, p_ss2_reg;
    logic signed [N+2:0]  y0_p_reg, y0_r_reg;
    logic signed [RW-1:0] r_cx1_reg, r_cx2_reg, r_s1_reg, r_ss1_reg, r_ss2_reg;

    // round to nearest, ties away from zero: bias negatives down by one
    function automatic logic signed [RW-1:0] rnd(logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + HALF - PW'(p[PW-1]);
        return t[PW-1:F];
    endfunction

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            y0_p_reg  <= y0_in;
            p_cx1_reg <= PW'(sum) * PW'(K_CX1);
            p_cx2_reg <= PW'(ds) * PW'(K_CX2);
            p_s1_reg  <= PW'(dd) * PW'(K_S1);
            p_ss1_reg <= PW'(d23) * PW'(K_SS1);
            p_ss2_reg <= PW'(d14) * PW'(K_SS2);
        end
        if (en[1]) begin
            y0_r_reg  <= y0_p_reg;
            r_cx1_reg <= rnd(p_cx1_reg);
            r_cx2_reg <= rnd(p_cx2_reg);
            r_s1_reg  <= rnd(p_s1_reg);
            r_ss1_reg <= rnd(p_ss1_reg);
            r_ss2_reg <= rnd(p_ss2_reg);
        end
    end

    assign y0_out = y0_r_reg;
    assign r_cx1  = r_cx1_reg;
    assign r_cx2  = r_cx2_reg;
    assign r_s1   = r_s1_reg;
    assign r_ss1  = r_ss1_reg;
    assign r_ss2  = r_ss2_reg;

endmodule

`default_nettype wire

// ===== rtl/r5dft_post.sv =====
// post-adder stages: combine rounded products into the five output bins
// no package dependencies
`default_nettype none

module r5dft_post #(
    parameter int N = 16
) (
    input  wire logic                aclk,
    input  wire logic [1:0]          en,
    input  wire logic signed [N+2:0] y0_re,
    input  wire logic signed [N+2:0] y0_im,
    input  wire logic signed [N+3:0] cx1_re,
    input  wire logic signed [N+3:0] cx2_re,
    input  wire logic signed [N+3:0] s1_re,
    input  wire logic signed [N+3:0] ss1_re,
    input  wire logic signed [N+3:0] ss2_re,
    input  wire logic signed [N+3:0] cx1_im,
    input  wire logic signed [N+3:0] cx2_im,
    input  wire logic signed [N+3:0] s1_im,
    input  wire logic signed [N+3:0] ss1_im,
    input  wire logic signed [N+3:0] ss2_im,
    output logic signed [N+2:0]      o0_re,
    output logic signed [N+2:0]      o0_im,
    output logic signed [N+2:0]      o1_re,
    output logic signed [N+2:0]      o1_im,
    output logic signed [N+2:0]      o2_re,
    output logic signed [N+2:0]      o2_im,
    output logic signed [N+2:0]      o3_re,
    output logic signed [N+2:0]      o3_im,
    output logic signed [N+2:0]      o4_re,
    output logic signed [N+2:0]      o4_im
);

    localparam int W5 = N + 5;
    localparam int OW = N + 3;

    logic signed [OW-1:0] y0_re_reg, y0_im_reg;
    logic signed [W5-1:0] p_re_reg, q_re_reg, u_re_reg, w_re_reg;
    logic signed [W5-1:0] p_im_reg, q_im_reg, u_im_reg, w_im_reg;
    logic signed [W5-1:0] t1_re, t1_im, t2_re, t2_im, t3_re, t3_im, t4_re, t4_im;
    logic signed [OW-1:0] o_reg [10];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            y0_re_reg <= y0_re;
            y0_im_reg <= y0_im;
            p_re_reg  <= W5'(y0_re) - W5'(cx1_re) + W5'(cx2_re);
            q_re_reg  <= W5'(y0_re) - W5'(cx1_re) - W5'(cx2_re);
            u_re_reg  <= W5'(s1_re) - W5'(ss1_re);
            w_re_reg  <= W5'(s1_re) + W5'(ss2_re);
            p_im_reg  <= W5'(y0_im) - W5'(cx1_im) + W5'(cx2_im);
            q_im_reg  <= W5'(y0_im) - W5'(cx1_im) - W5'(cx2_im);
            u_im_reg  <= W5'(s1_im) - W5'(ss1_im);
            w_im_reg  <= W5'(s1_im) + W5'(ss2_im);
        end
    end

    // rotations by j swap components; low bits are exact, results fit OW
    always_comb begin
        t1_re = p_re_reg - u_im_reg;
        t1_im = p_im_reg + u_re_reg;
        t2_re = q_re_reg - w_im_reg;
        t2_im = q_im_reg + w_re_reg;
        t3_re = q_re_reg + w_im_reg;
        t3_im = q_im_reg - w_re_reg;
        t4_re = p_re_reg + u_im_reg;
        t4_im = p_im_reg - u_re_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            o_reg[0] <= y0_re_reg;
            o_reg[1] <= y0_im_reg;
            o_reg[2] <= t1_re[OW-1:0];
            o_reg[3] <= t1_im[OW-1:0];
            o_reg[4] <= t2_re[OW-1:0];
            o_reg[5] <= t2_im[OW-1:0];
            o_reg[6] <= t3_re[OW-1:0];
            o_reg[7] <= t3_im[OW-1:0];
            o_reg[8] <= t4_re[OW-1:0];
            o_reg[9] <= t4_im[OW-1:0];
        end
    end

    assign o0_re = o_reg[0];
    assign o0_im = o_reg[1];
    assign o1_re = o_reg[2];
    assign o1_im = o_reg[3];
    assign o2_re = o_reg[4];
    assign o2_im = o_reg[5];
    assign o3_re = o_reg[6];
    assign o3_im = o_reg[7];
    assign o4_re = o_reg[8];
    assign o4_im = o_reg[9];

endmodule

`default_nettype wire

// ===== tb/radix5_dft_butterfly_tb.sv =====
// self-checking testbench for radix5_dft_butterfly: five-point dft per item
// depends on r5dft_pkg and the radix5_dft_butterfly rtl
`default_nettype none

module radix5_dft_butterfly_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = r5dft_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC        = r5dft_pkg::COEF_FRAC_BITS_DEF;
    localparam int OUT_BITS    = SAMPLE_BITS + 3;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_TAIL   = 120;
    localparam int CYCLE_LIMIT  = 200000;

    // constant magnitudes rounded from q30 to FRAC fraction bits, halves up
    localparam longint K_CX1 =
        longint'((r5dft_pkg::Q30_CX1 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint K_CX2 =
        longint'((r5dft_pkg::Q30_CX2 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint K_S1  =
        longint'((r5dft_pkg::Q30_S1  + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint K_SS1 =
        longint'((r5dft_pkg::Q30_SS1 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint K_SS2 =
        longint'((r5dft_pkg::Q30_SS2 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));

    // index 2*n + 0 is the real part of sample/bin n, 2*n + 1 the imaginary part
    typedef logic [9:0][SAMPLE_BITS-1:0] samples_t;
    typedef logic [9:0][OUT_BITS-1:0]    bins_t;

    class dft_scoreboard;
        bins_t pending[$];
        int    failures;

        function new();
            failures = 0;
        endfunction

        // round(v * k / 2^FRAC), ties away from zero
        static function longint scaled(longint v, longint k);
            longint mag;
            mag = (((v < 0) ? -v : v) * k + (longint'(1) << (FRAC - 1))) >>> FRAC;
            return (v < 0) ? -mag : mag;
        endfunction

        static function bins_t dft5(samples_t x);
            longint xs[5][2];
            longint y0[2], p[2], q[2], u[2], w[2];
            longint s14, s23, d14, d23, total, a, b, cc;
            bins_t y;
            for (int n = 0; n < 5; n++) begin
                for (int c = 0; c < 2; c++) begin
                    xs[n][c] = longint'($signed(x[2*n + c]));
                end
            end
            for (int c = 0; c < 2; c++) begin
                s14 = xs[1][c] + xs[4][c];
                s23 = xs[2][c] + xs[3][c];
                d14 = xs[1][c] - xs[4][c];
                d23 = xs[2][c] - xs[3][c];
                total = s14 + s23;
                y0[c] = xs[0][c] + total;
                // the -1.25 term: rounding is symmetric, so negate afterwards
                a = y0[c] - scaled(total, K_CX1);
                b = scaled(s14 - s23, K_CX2);
                p[c] = a + b;
                q[c] = a - b;
                cc = scaled(d23 - d14, K_S1);
                u[c] = cc - scaled(d23, K_SS1);
                w[c] = cc + scaled(d14, K_SS2);
            end
            y[0] = OUT_BITS'(y0[0]);
            y[1] = OUT_BITS'(y0[1]);
            y[2] = OUT_BITS'(p[0] - u[1]);
            y[3] = OUT_BITS'(p[1] + u[0]);
            y[4] = OUT_BITS'(q[0] - w[1]);
            y[5] = OUT_BITS'(q[1] + w[0]);
            y[6] = OUT_BITS'(q[0] + w[1]);
            y[7] = OUT_BITS'(q[1] - w[0]);
            y[8] = OUT_BITS'(p[0] + u[1]);
            y[9] = OUT_BITS'(p[1] - u[0]);
            return y;
        endfunction

        function void note_input(samples_t x);
            pending.push_back(dft5(x));
        endfunction

        function void check_result(bins_t got);
            bins_t want;
            if (pending.size() == 0) begin
                if (failures < 10) $display("unexpected result item at %0t", $realtime);
                failures++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 10; i++) begin
                if (got[i] !== want[i]) begin
                    if (failures < 10) begin
                        $display("mismatch y%0d_%s at %0t: expected %0d, got %0d", i / 2,
                                 (i % 2) ? "im" : "re", $realtime,
                                 $signed(want[i]), $signed(got[i]));
                    end
                    failures++;
                end
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    samples_t s_samples = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bins_t    m_bins;

    logic signed [OUT_BITS-1:0] y0_re, y0_im, y1_re, y1_im, y2_re, y2_im;
    logic signed [OUT_BITS-1:0] y3_re, y3_im, y4_re, y4_im;

    dft_scoreboard sb = new();
    int unsigned   cycles = 0;
    int unsigned   stall_pct = 0;
    int unsigned   gap_pct = 0;

    always #2 aclk = ~aclk;

    radix5_dft_butterfly dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_x0_re (s_samples[0]),
        .s_x0_im (s_samples[1]),
        .s_x1_re (s_samples[2]),
        .s_x1_im (s_samples[3]),
        .s_x2_re (s_samples[4]),
        .s_x2_im (s_samples[5]),
        .s_x3_re (s_samples[6]),
        .s_x3_im (s_samples[7]),
        .s_x4_re (s_samples[8]),
        .s_x4_im (s_samples[9]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_y0_re (y0_re),
        .m_y0_im (y0_im),
        .m_y1_re (y1_re),
        .m_y1_im (y1_im),
        .m_y2_re (y2_re),
        .m_y2_im (y2_im),
        .m_y3_re (y3_re),
        .m_y3_im (y3_im),
        .m_y4_re (y4_re),
        .m_y4_im (y4_im)
    );

    assign m_bins = {y4_im, y4_re, y3_im, y3_re, y2_im, y2_re, y1_im, y1_re, y0_im, y0_re};

    // input accepted before result checked, so even a combinational path still lines up
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_samples);
            if (m_valid && m_ready) sb.check_result(m_bins);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("radix5_dft_butterfly test failed");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input samples_t x);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_samples <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2, 3: return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic samples_t pick_item();
        samples_t x;
        for (int i = 0; i < 10; i++) x[i] = pick_sample();
        // symmetric or antisymmetric pairs zero out the sum or difference paths
        case ($urandom_range(0, 7))
            0: begin
                x[8] = x[2]; x[9] = x[3]; x[6] = x[4]; x[7] = x[5];
            end
            1: begin
                x[8] = -x[2]; x[9] = -x[3]; x[6] = -x[4]; x[7] = -x[5];
            end
            default: ;
        endcase
        return x;
    endfunction

    initial begin
        samples_t x;
        logic [SAMPLE_BITS-1:0] vmax, vmin;
        vmax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        vmin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero, full scale, impulses, rounding ties
        send_item('0);
        send_item({10{vmax}});
        send_item({10{vmin}});
        send_item({vmin, vmax, vmin, vmax, vmin, vmax, vmin, vmax, vmin, vmax});
        send_item({vmax, vmin, vmin, vmax, vmax, vmin, vmin, vmax, vmax, vmin});
        send_item({vmin, vmin, vmax, vmax, vmax, vmax, vmin, vmin, vmax, vmax});
        for (int n = 0; n < 10; n++) begin
            x = '0;
            x[n] = (n % 2) ? vmin : vmax;
            send_item(x);
        end
        // sum of 2: -1.25 product on a half
        x = '0; x[2] = SAMPLE_BITS'(1); x[8] = SAMPLE_BITS'(1);
        send_item(x);
        x = '0; x[3] = '1; x[9] = '1;                // negative tie
        send_item(x);
        // small differences
        x = '0; x[4] = SAMPLE_BITS'(1); x[6] = '1; x[5] = SAMPLE_BITS'(3);
        send_item(x);
        x = {10{16'h5555}};
        send_item(x);
        x = {10{16'haaaa}};
        send_item(x);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 25;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            if (k >= RANDOM_ITEMS - QUIET_TAIL) begin
                gap_pct = 0;
                stall_pct = 0;
            end
            send_item(pick_item());
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (r5dft_pkg::PIPE_STAGES + 4) @(posedge aclk);

        if (sb.pending.size() != 0) $display("%0d results never arrived", sb.pending.size());
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("radix5_dft_butterfly test passed");
        end else begin
            $display("radix5_dft_butterfly test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
